// ===== rtl/bscf_pkg.sv =====
// Package for the bitmap set/count/find block: sizes, request codes,
// per-word statistics type and the word population count function.
// No dependencies.
`default_nettype none

package bscf_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int WSEL_W    = $clog2(NWORDS);
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int WCNT_W    = OFF_W + 1;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_SET   = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_FLIP  = 3'd4
  } req_t;

  typedef struct packed {
    logic              any;
    logic [WCNT_W-1:0] cnt;
    logic [OFF_W-1:0]  lo;
    logic [OFF_W-1:0]  hi;
  } word_stat_t;

  function automatic logic [WCNT_W-1:0] pop_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] c;
    logic [WORD_BITS-1:0] d;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c * 32'h0101_0101;
    return d[WORD_BITS-8 +: WCNT_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bscf_word_scan.sv =====
// Statistics of one bitmap word: population count, lowest and highest set bit.
// Depends on bscf_pkg.
`default_nettype none

module bscf_word_scan
  import bscf_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word,
  output word_stat_t                stat
);

  always_comb begin
    stat.any = |word;
    stat.cnt = pop_word(word);
    stat.lo  = '0;
    stat.hi  = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word[b]) begin
        stat.lo = OFF_W'(b);
      end
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (word[b]) begin
        stat.hi = OFF_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_set_count_find.sv =====
// Bitmap with population count and lowest/highest set bit search.
// Depends on bscf_pkg and bscf_word_scan.
//
//   channel  dir  tdata fields (low bit first)
//   s_axis   in   req_type[2:0] bit_index[10:3] write_value[11]
//   m_axis   out  bit_value[0] ones_count[9:1] highest_set[18:10]
//                 lowest_set[27:19] none_set[28]
//   cfg      in   active_width[8:0], written when cfg_wr_en is high
//
// One request is taken every cycle while the output is not stalled; each result
// is valid once it has passed the word statistics and result registers behind the map.
// The map is updated in the cycle of the transfer; the statistics follow it.
// A stalled output stalls the whole pipeline and drops s_axis_tready.
// Reset clears the map, the width to 256 and all valid flags.
`default_nettype none

module bitmap_set_count_find
  import bscf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // req_type, bit_index, write_value
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // bit_value, ones_count, highest_set,
                                               // lowest_set, none_set
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data
);

  logic [MAX_WIDTH-1:0] bit_map;
  logic [MAX_WIDTH-1:0] bit_map_next;
  logic [MAX_WIDTH-1:0] used_mask;
  logic [CNT_W-1:0]     active_width;
  logic [CNT_W-1:0]     eff_width;
  logic                 adv;
  logic                 acc;
  logic [2:0]           req_type;
  logic [IDX_W-1:0]     bit_index;
  logic                 write_value;
  logic                 in_range;
  logic                 bv0;
  logic                 v1;
  logic                 bv1;
  logic                 v2;
  logic                 bv2;
  word_stat_t           stat_w [NWORDS];
  word_stat_t           stat2  [NWORDS];
  logic [CNT_W-1:0]     cnt_sum;
  logic [CNT_W-1:0]     lo_idx;
  logic [CNT_W-1:0]     hi_idx;
  logic                 found;
  logic [OUT_W-1:0]     out_next;
  logic [OUT_W-1:0]     out_data;
  logic                 out_valid;

  assign req_type    = s_axis_tdata[2:0];
  assign bit_index   = s_axis_tdata[10:3];
  assign write_value = s_axis_tdata[11];

  assign adv           = !out_valid || m_axis_tready;
  assign acc           = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign eff_width = (active_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : active_width;
  assign in_range  = {1'b0, bit_index} < eff_width;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      used_mask[i] = CNT_W'(i) < eff_width;
    end
  end

  always_comb begin
    case (req_type)
      REQ_SET:   bit_map_next = '1;
      REQ_CLEAR: bit_map_next = '0;
      REQ_FLIP:  bit_map_next = ~bit_map;
      default:   bit_map_next = bit_map;
    endcase
    bit_map_next = bit_map_next & used_mask;
    if (req_type == REQ_WRITE && in_range) begin
      bit_map_next[bit_index] = write_value;
    end
    bv0 = in_range && bit_map_next[bit_index];
  end

  for (genvar w = 0; w < NWORDS; w++) begin : g_scan
    bscf_word_scan u_scan (
      .word (bit_map[w*WORD_BITS +: WORD_BITS]),
      .stat (stat_w[w])
    );
  end

  always_comb begin
    cnt_sum = '0;
    lo_idx  = eff_width + CNT_W'(1);
    hi_idx  = eff_width + CNT_W'(1);
    found   = 1'b0;
    for (int w = 0; w < NWORDS; w++) begin
      cnt_sum = cnt_sum + CNT_W'(stat2[w].cnt);
      if (stat2[w].any) begin
        hi_idx = CNT_W'({WSEL_W'(w), stat2[w].hi});
        found  = 1'b1;
      end
    end
    for (int w = NWORDS - 1; w >= 0; w--) begin
      if (stat2[w].any) begin
        lo_idx = CNT_W'({WSEL_W'(w), stat2[w].lo});
      end
    end
    out_next = {3'b000, !found, lo_idx, hi_idx, cnt_sum, bv2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_map      <= '0;
      active_width <= CNT_W'(MAX_WIDTH);
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_width <= cfg_wr_data;
      end
      if (acc) begin
        bit_map <= bit_map_next;
      end
      if (adv) begin
        v1        <= acc;
        v2        <= v1;
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bv1      <= bv0;
      bv2      <= bv1;
      stat2    <= stat_w;
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bscf_checker.sv =====
// Port-level checks for the bitmap set/count/find block, bound to its top level.
// Depends on bscf_pkg and bitmap_set_count_find.
`default_nettype none

module bscf_checker
  import bscf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output transfer changed.");

  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[28] == (m_axis_tdata[9:1] == 9'd0)))
    else $error("Empty flag disagrees with the count.");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[28] |-> m_axis_tdata[27:19] <= m_axis_tdata[18:10])
    else $error("Lowest set index above highest.");

  a_span: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[28] |->
      {1'b0, m_axis_tdata[9:1]} <=
      ({1'b0, m_axis_tdata[18:10]} - {1'b0, m_axis_tdata[27:19]} + 10'd1))
    else $error("Count exceeds the span of set bits.");

endmodule

bind bitmap_set_count_find bscf_checker u_bscf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
